/* sv/nfts_pkg.sv */
package nfts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int FREQ_W      = 32;
  localparam int ENTRY_IDX_W = 8;
  localparam int MATCH_W     = 8;
  localparam int CFG_W       = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_LO,
    S_CHK_HI,
    S_PROBE,
    S_LOWER,
    S_UPPER,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID_NEXT,
    ADDR_MID_DN,
    ADDR_MID_UP
  } addr_sel_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_LAST,
    RES_MID,
    RES_DN,
    RES_UP
  } res_sel_t;

  typedef struct packed {
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      load_query;
    logic      bounds_init;
    logic      probe_step;
    logic      res_load;
    res_sel_t  res_sel;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic q_lt;
    logic q_gt;
    logic probe_cont;
    logic mid_gt0;
    logic mid_up_ok;
    logic nb_closer;
  } dp_sts_t;

endpackage

/* sv/nfts_ram.sv */
module nfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/nfts_ctrl.sv */
module nfts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nfts_pkg::dp_sts_t sts,
  output nfts_pkg::dp_cmd_t cmd
);

  nfts_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic             out_free;
  logic             exact;

  assign in_xfer  = in_valid && (state_r == nfts_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign exact    = !sts.q_lt && !sts.q_gt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nfts_pkg::S_IDLE: begin
        if (in_xfer && in_func) state_nxt = nfts_pkg::S_CHK_LO;
      end
      nfts_pkg::S_CHK_LO: begin
        state_nxt = sts.q_lt ? nfts_pkg::S_DONE : nfts_pkg::S_CHK_HI;
      end
      nfts_pkg::S_CHK_HI: begin
        state_nxt = sts.q_gt ? nfts_pkg::S_DONE : nfts_pkg::S_PROBE;
      end
      nfts_pkg::S_PROBE: begin
        if (exact || !sts.probe_cont) begin
          if (sts.mid_gt0)        state_nxt = nfts_pkg::S_LOWER;
          else if (sts.mid_up_ok) state_nxt = nfts_pkg::S_UPPER;
          else                    state_nxt = nfts_pkg::S_DONE;
        end
      end
      nfts_pkg::S_LOWER: begin
        if (sts.nb_closer)      state_nxt = nfts_pkg::S_DONE;
        else if (sts.mid_up_ok) state_nxt = nfts_pkg::S_UPPER;
        else                    state_nxt = nfts_pkg::S_DONE;
      end
      nfts_pkg::S_UPPER: begin
        state_nxt = nfts_pkg::S_DONE;
      end
      nfts_pkg::S_DONE: begin
        if (out_free) state_nxt = nfts_pkg::S_IDLE;
      end
      default: state_nxt = nfts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.addr_sel    = nfts_pkg::ADDR_ZERO;
    cmd.res_sel     = nfts_pkg::RES_MID;
    unique case (state_r)
      nfts_pkg::S_IDLE: begin
        cmd.ram_we     = in_xfer && !in_func;
        cmd.load_query = in_xfer && in_func;
      end
      nfts_pkg::S_CHK_LO: begin
        cmd.addr_sel = nfts_pkg::ADDR_LAST;
        cmd.res_load = sts.q_lt;
        cmd.res_sel  = nfts_pkg::RES_ZERO;
      end
      nfts_pkg::S_CHK_HI: begin
        cmd.res_load    = sts.q_gt;
        cmd.res_sel     = nfts_pkg::RES_LAST;
        cmd.bounds_init = !sts.q_gt;
        cmd.addr_sel    = nfts_pkg::ADDR_MID_NEXT;
      end
      nfts_pkg::S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (exact || !sts.probe_cont) begin
          if (sts.mid_gt0) begin
            cmd.addr_sel = nfts_pkg::ADDR_MID_DN;
          end else if (sts.mid_up_ok) begin
            cmd.addr_sel = nfts_pkg::ADDR_MID_UP;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = nfts_pkg::RES_MID;
          end
        end else begin
          cmd.addr_sel = nfts_pkg::ADDR_MID_NEXT;
        end
      end
      nfts_pkg::S_LOWER: begin
        cmd.addr_sel = nfts_pkg::ADDR_MID_UP;
        if (sts.nb_closer) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = nfts_pkg::RES_DN;
        end else if (!sts.mid_up_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = nfts_pkg::RES_MID;
        end
      end
      nfts_pkg::S_UPPER: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = sts.nb_closer ? nfts_pkg::RES_UP : nfts_pkg::RES_MID;
      end
      nfts_pkg::S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.addr_sel = nfts_pkg::ADDR_ZERO;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)      out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == nfts_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/nfts_dp.sv */
module nfts_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [nfts_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [nfts_pkg::FREQ_W-1:0]      in_entry_freq,
  input  logic [nfts_pkg::FREQ_W-1:0]      in_query_freq,
  input  logic                             cfg_wr_en,
  input  logic [nfts_pkg::CFG_W-1:0]       cfg_wr_data,
  input  nfts_pkg::dp_cmd_t                cmd,
  output nfts_pkg::dp_sts_t                sts,
  output logic [nfts_pkg::MATCH_W-1:0]     out_match_index
);

  localparam int IW = nfts_pkg::IDX_W;
  localparam int CW = nfts_pkg::CNT_W;
  localparam int FW = nfts_pkg::FREQ_W;

  logic [nfts_pkg::CFG_W-1:0]   entries_r;
  logic [FW-1:0]                q_r;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hip1_r, hip1_nxt;
  logic [IW-1:0]                mid_r;
  logic [FW-1:0]                here_r;
  logic [IW-1:0]                res_r, res_nxt;
  logic [nfts_pkg::MATCH_W-1:0] match_r;

  logic [CW-1:0] n_used;
  logic [IW-1:0] last_idx;
  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid_calc;
  logic [CW-1:0] mid_ext;
  logic [FW-1:0] rdata;
  logic [FW-1:0] abs_gap;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          wr_ok;
  logic          q_lt, q_gt;

  always_comb begin
    if (entries_r == '0) begin
      n_used = CW'(1);
    end else if (32'(entries_r) > 32'(nfts_pkg::TABLE_DEPTH)) begin
      n_used = CW'(nfts_pkg::TABLE_DEPTH);
    end else begin
      n_used = CW'(entries_r);
    end
  end
  assign last_idx = IW'(n_used - CW'(1));

  assign q_lt    = q_r < rdata;
  assign q_gt    = q_r > rdata;
  assign abs_gap = (q_r >= rdata) ? (q_r - rdata) : (rdata - q_r);
  assign mid_ext = CW'(mid_r);

  always_comb begin
    lo_nxt   = lo_r;
    hip1_nxt = hip1_r;
    if (cmd.bounds_init) begin
      lo_nxt   = '0;
      hip1_nxt = n_used;
    end else if (cmd.probe_step) begin
      if (q_lt)      hip1_nxt = mid_ext;
      else if (q_gt) lo_nxt   = mid_ext + CW'(1);
    end
  end

  assign mid_sum  = {1'b0, lo_nxt} + {1'b0, hip1_nxt} - (CW+1)'(1);
  assign mid_calc = IW'(mid_sum[CW:1]);

  always_comb begin
    case (cmd.addr_sel)
      nfts_pkg::ADDR_ZERO:     raddr = '0;
      nfts_pkg::ADDR_LAST:     raddr = last_idx;
      nfts_pkg::ADDR_MID_NEXT: raddr = mid_calc;
      nfts_pkg::ADDR_MID_DN:   raddr = mid_r - IW'(1);
      nfts_pkg::ADDR_MID_UP:   raddr = mid_r + IW'(1);
      default:                 raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.res_sel)
      nfts_pkg::RES_ZERO: res_nxt = '0;
      nfts_pkg::RES_LAST: res_nxt = last_idx;
      nfts_pkg::RES_MID:  res_nxt = mid_r;
      nfts_pkg::RES_DN:   res_nxt = mid_r - IW'(1);
      nfts_pkg::RES_UP:   res_nxt = mid_r + IW'(1);
      default:            res_nxt = mid_r;
    endcase
  end

  assign wr_ok = 32'(in_entry_index) < 32'(nfts_pkg::TABLE_DEPTH);
  assign waddr = IW'(in_entry_index);

  nfts_ram #(
    .WIDTH (FW),
    .DEPTH (nfts_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ram_we && wr_ok),
    .waddr (waddr),
    .wdata (in_entry_freq),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= nfts_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) q_r <= in_query_freq;
    lo_r   <= lo_nxt;
    hip1_r <= hip1_nxt;
    if (cmd.bounds_init || (cmd.probe_step && (q_lt || q_gt) && (lo_nxt < hip1_nxt))) begin
      mid_r <= mid_calc;
    end
    if (cmd.probe_step) here_r <= abs_gap;
    if (cmd.res_load) res_r <= res_nxt;
    if (cmd.out_load) match_r <= nfts_pkg::MATCH_W'(res_r);
  end

  assign sts.q_lt       = q_lt;
  assign sts.q_gt       = q_gt;
  assign sts.probe_cont = lo_nxt < hip1_nxt;
  assign sts.mid_gt0    = mid_r != '0;
  assign sts.mid_up_ok  = (mid_ext + CW'(1)) < n_used;
  assign sts.nb_closer  = abs_gap < here_r;

  assign out_match_index = match_r;

endmodule

/* sv/nearest_frequency_table_search.sv */
// Write: the entry lands in the table RAM at the accept edge.
// Query: accept, a check of the first and of the last entry, P probes (at most
// log2(entries) + 1, nine for 256) and 0 to 2 neighbour reads, then the result loads
// the output register; a query beyond either end skips the probes. One item in flight:
// next accept in the cycle after the result loads; a query holds while the last waits.
// rst_n (synchronous) empties the output and sets entries_in_use to 256; table is kept.
module nearest_frequency_table_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [nfts_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [nfts_pkg::FREQ_W-1:0]      in_entry_freq,
  input  logic [nfts_pkg::FREQ_W-1:0]      in_query_freq,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nfts_pkg::MATCH_W-1:0]     out_match_index,
  input  logic                             cfg_wr_en,
  input  logic [nfts_pkg::CFG_W-1:0]       cfg_wr_data
);

  nfts_pkg::dp_cmd_t cmd;
  nfts_pkg::dp_sts_t sts;

  nfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nfts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_entry_index  (in_entry_index),
    .in_entry_freq   (in_entry_freq),
    .in_query_freq   (in_query_freq),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_match_index (out_match_index)
  );

endmodule

/* dv/tb.sv */
module tb;
  import nfts_pkg::*;

  localparam logic FUNC_WRITE      = 1'b0;
  localparam logic FUNC_QUERY      = 1'b1;
  localparam int   SETTLE_CYCLES   = 24;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam int   QUIET_LIMIT     = 3000;
  localparam int   MAX_REPORTS     = 50;

  typedef enum {LOAD_WIDE, LOAD_DENSE, LOAD_TOP} load_kind_t;

  typedef struct packed {
    logic                   func;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [FREQ_W-1:0]      efreq;
    logic [FREQ_W-1:0]      qfreq;
  } search_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  qfreq;
    logic [MATCH_W-1:0] idx;
  } match_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic                   in_func         = 1'b0;
  logic [ENTRY_IDX_W-1:0] in_entry_index  = '0;
  logic [FREQ_W-1:0]      in_entry_freq   = '0;
  logic [FREQ_W-1:0]      in_query_freq   = '0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [MATCH_W-1:0]     out_match_index;
  logic                   cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data     = '0;

  search_item_t      pending_items[$];
  match_t            expected_match[$];
  logic [FREQ_W-1:0] table_shadow[TABLE_DEPTH];
  logic [FREQ_W-1:0] plan_freq[TABLE_DEPTH];
  logic [CFG_W-1:0]  span_reg  = CFG_RESET;
  int                plan_span = TABLE_DEPTH;

  logic in_taken   = 1'b0;
  bit   idle_on    = 1'b1;
  int   tx_gap     = 0;
  int   rx_gap     = 0;
  int   stall_ask  = 0;
  int   stall_seen = 0;
  int   n_errors   = 0;
  int   n_queries  = 0;
  int   n_writes   = 0;
  int   n_settings = 0;

  nearest_frequency_table_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_freq   (in_entry_freq),
    .in_query_freq   (in_query_freq),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_index (out_match_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int used_entries(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(c);
  endfunction

  function automatic logic [FREQ_W-1:0] distance(logic [FREQ_W-1:0] a, logic [FREQ_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [MATCH_W-1:0] nearest_entry(logic [FREQ_W-1:0] q);
    int                n;
    int                lo;
    int                hi;
    int                mid;
    int                pick;
    bit                hit;
    logic [FREQ_W-1:0] here;
    n = used_entries(span_reg);
    if (q < table_shadow[0]) return '0;
    if (q > table_shadow[n-1]) return MATCH_W'(n - 1);
    lo = 0;
    hi = n - 1;
    mid = 0;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = (lo + hi) >> 1;
      if (table_shadow[mid] > q) hi = mid - 1;
      else if (table_shadow[mid] < q) lo = mid + 1;
      else hit = 1'b1;
    end
    here = distance(q, table_shadow[mid]);
    pick = mid;
    if (mid > 0 && distance(q, table_shadow[mid-1]) < here) pick = mid - 1;
    else if (mid + 1 < n && distance(q, table_shadow[mid+1]) < here) pick = mid + 1;
    return MATCH_W'(pick);
  endfunction

  function automatic logic [FREQ_W-1:0] tie_point(int i);
    logic [FREQ_W:0] pair_sum;
    pair_sum = {1'b0, plan_freq[i]} + {1'b0, plan_freq[i+1]};
    return FREQ_W'(pair_sum >> 1);
  endfunction

  function automatic logic [FREQ_W-1:0] pick_query();
    int i;
    i = $urandom_range(0, plan_span - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return plan_freq[i];
      3, 4: begin
        if ($urandom_range(0, 1) != 0) return plan_freq[i] + $urandom_range(1, 3);
        return plan_freq[i] - $urandom_range(1, 3);
      end
      5, 6: begin
        if (i == TABLE_DEPTH - 1 || (i == plan_span - 1 && i > 0)) i = i - 1;
        return tie_point(i) + FREQ_W'($urandom_range(0, 1));
      end
      7: return $urandom;
      8: return ($urandom_range(0, 1) != 0) ? {FREQ_W{1'b1}} : {FREQ_W{1'b0}};
      default: begin
        if ($urandom_range(0, 1) != 0) return plan_freq[0] - 1;
        return plan_freq[plan_span-1] + 1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic push_write(int idx, logic [FREQ_W-1:0] f);
    search_item_t it;
    it.func  = FUNC_WRITE;
    it.idx   = ENTRY_IDX_W'(idx);
    it.efreq = f;
    it.qfreq = $urandom;
    pending_items.push_back(it);
    plan_freq[idx] = f;
  endtask

  task automatic push_query(logic [FREQ_W-1:0] q);
    search_item_t it;
    it.func  = FUNC_QUERY;
    it.idx   = ENTRY_IDX_W'($urandom);
    it.efreq = $urandom;
    it.qfreq = q;
    pending_items.push_back(it);
  endtask

  task automatic load_table(load_kind_t kind);
    logic [FREQ_W-1:0] f;
    case (kind)
      LOAD_WIDE: f = '0;
      LOAD_TOP:  f = 32'hFFFF_FD02;
      default:   f = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i > 0)
        f = f + ((kind == LOAD_WIDE) ? $urandom_range(0, 24'hFF_FFFF) : $urandom_range(0, 3));
      push_write(i, (kind == LOAD_WIDE && i == TABLE_DEPTH - 1) ? {FREQ_W{1'b1}} : f);
    end
  endtask

  task automatic random_write();
    int                i;
    longint unsigned   lo;
    longint unsigned   hi;
    i = $urandom_range(0, TABLE_DEPTH - 1);
    lo = (i > 0) ? longint'(plan_freq[i-1]) : 0;
    hi = (i < TABLE_DEPTH - 1) ? longint'(plan_freq[i+1]) : 64'hFFFF_FFFF;
    if (lo <= hi && $urandom_range(0, 7) != 0)
      push_write(i, FREQ_W'(lo + ({$urandom, $urandom} % (hi - lo + 1))));
    else
      push_write(i, $urandom);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_match.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_span(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    span_reg  = v;
    plan_span = used_entries(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] span, int n_items, bit idle, bit hold_off);
    drain();
    set_span(span);
    idle_on = idle;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) == 0) random_write();
      else push_query(pick_query());
    end
    if (hold_off) stall_ask++;
  endtask

  always @(negedge clk) begin : drive_in
    search_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_func        <= it.func;
        in_entry_index <= it.idx;
        in_entry_freq  <= it.efreq;
        in_query_freq  <= it.qfreq;
        if (idle_on && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      rx_gap     <= HOLD_OFF_CYCLES;
      out_ready  <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap    <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    match_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WRITE) begin
          table_shadow[in_entry_index] = in_entry_freq;
          n_writes++;
        end else begin
          want.qfreq = in_query_freq;
          want.idx   = nearest_entry(in_query_freq);
          expected_match.push_back(want);
          n_queries++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_match.size() == 0) begin
          report_mismatch($sformatf("unexpected result match_index %0d", out_match_index));
        end else begin
          want = expected_match.pop_front();
          if (out_match_index !== want.idx)
            report_mismatch($sformatf("query %0d: match_index %0d, expected %0d",
                                      want.qfreq, out_match_index, want.idx));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] saved;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    set_span(CFG_RESET);

    load_table(LOAD_WIDE);
    push_query({FREQ_W{1'b0}});
    push_query({FREQ_W{1'b1}});
    push_query(plan_freq[100]);
    push_query(tie_point(40));
    push_query(tie_point(40) + 1);
    push_query(plan_freq[7] + 1);
    push_query(plan_freq[200] - 1);
    push_query(plan_freq[254] + 1);
    push_write(60, plan_freq[61]);
    push_query(plan_freq[61]);
    saved = plan_freq[128];
    push_write(128, {FREQ_W{1'b0}});
    push_query(plan_freq[127]);
    push_query(plan_freq[129]);
    push_write(128, saved);
    drain();
    set_span(CFG_W'(1));
    push_query({FREQ_W{1'b0}});
    push_query({FREQ_W{1'b1}});
    push_query(plan_freq[0] + 5);
    drain();
    set_span(CFG_W'(2));
    push_query(tie_point(0));
    push_query(plan_freq[1]);

    run_phase(CFG_W'(3), 110, 1'b1, 1'b0);
    run_phase(CFG_RESET, 140, 1'b1, 1'b1);
    load_table(LOAD_DENSE);
    run_phase(CFG_W'($urandom_range(4, 255)), 120, 1'b0, 1'b0);
    run_phase(CFG_W'(0), 50, 1'b1, 1'b0);
    run_phase(CFG_W'(511), 120, 1'b1, 1'b0);
    load_table(LOAD_TOP);
    run_phase(CFG_W'(2), 70, 1'b1, 1'b0);
    run_phase(CFG_W'($urandom_range(257, 510)), 120, 1'b1, 1'b0);
    run_phase(CFG_W'($urandom_range(1, 256)), 120, 1'b1, 1'b1);
    run_phase(CFG_RESET, 150, 1'b0, 1'b0);
    drain();

    $display("Checked %0d nearest-entry lookups after %0d table writes,", n_queries, n_writes);
    $display("over %0d table sizes from zero to saturation, with stalls on both sides.",
             n_settings);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
